FILE: rtl/amms_pkg.sv
// Shared constants, codes and control types for the min/max/sum/average reduction block.
package amms_pkg;

  localparam int DATA_W       = 32;
  localparam int MAX_ELEMENTS = 4096;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int STEP_W       = $clog2(DATA_W);

  typedef enum logic [1:0] {
    OP_MIN = 2'd0,
    OP_MAX = 2'd1,
    OP_SUM = 2'd2,
    OP_AVG = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic fold;         // fold the accepted element into the run state
    logic div_start;    // run ends with an average: load the divider
    logic div_step;     // one quotient bit
    logic load_direct;  // capture min, max or sum into the output register
    logic load_div;     // capture the signed quotient into the output register
  } amms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_avg;       // the run that the current element belongs to averages
  } amms_status_t;

endpackage

FILE: rtl/amms_ctrl.sv
// Controller state machine: intake, average division sequencing and output register valid.
module amms_ctrl
  import amms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         last,
  output logic         out_valid,
  input  logic         out_ready,
  input  amms_status_t status,
  output amms_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_WAIT
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;
  logic                out_free;
  logic                acc;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_ACC) && out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.fold        = acc;
    cmd.div_start   = acc && last && status.is_avg;
    cmd.load_direct = acc && last && !status.is_avg;
    cmd.div_step    = (state == ST_DIV);
    cmd.load_div    = (state == ST_WAIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_direct || cmd.load_div) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (cmd.div_start) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DATA_W - 1)) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

endmodule

FILE: rtl/amms_dp.sv
// Datapath: run accumulator, element counter, bit-serial divider and output register.
module amms_dp
  import amms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               operation,
  input  logic signed [DATA_W-1:0] element,
  input  amms_cmd_t                cmd,
  output amms_status_t             status,
  output logic signed [DATA_W-1:0] value,
  output logic                     count_overflow
);

  logic signed [DATA_W-1:0] running;
  logic [CNT_W-1:0]         count;
  op_t                      held_op;
  logic                     started;
  logic                     ovf;

  op_t                      op_eff;
  logic signed [DATA_W-1:0] running_next;
  logic [CNT_W-1:0]         count_next;
  logic                     ovf_next;

  logic [CNT_W-1:0]         rem;
  logic [DATA_W-1:0]        quo;
  logic [CNT_W-1:0]         divisor;
  logic                     neg;
  logic                     div_ovf;
  logic [CNT_W:0]           rem_sh;
  logic                     q_bit;
  logic [CNT_W:0]           rem_sub;

  assign op_eff        = started ? held_op : op_t'(operation);
  assign status.is_avg = (op_eff == OP_AVG);

  always_comb begin
    running_next = running;
    count_next   = count;
    ovf_next     = ovf;
    if (!started) begin
      running_next = element;
      count_next   = CNT_W'(1);
      ovf_next     = 1'b0;
    end else if (count >= CNT_W'(MAX_ELEMENTS)) begin
      ovf_next = 1'b1;
    end else begin
      count_next = count + CNT_W'(1);
      case (held_op)
        OP_MIN:  running_next = (element < running) ? element : running;
        OP_MAX:  running_next = (element > running) ? element : running;
        default: running_next = running + element;
      endcase
    end
  end

  // Restoring division step on magnitudes.
  assign rem_sh  = {rem, quo[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign q_bit   = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      count   <= '0;
      ovf     <= 1'b0;
      held_op <= OP_MIN;
      running <= '0;
    end else if (cmd.fold) begin
      if (cmd.div_start || cmd.load_direct) begin
        started <= 1'b0;
        count   <= '0;
        ovf     <= 1'b0;
        held_op <= OP_MIN;
        running <= '0;
      end else begin
        started <= 1'b1;
        count   <= count_next;
        ovf     <= ovf_next;
        held_op <= op_eff;
        running <= running_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      quo     <= running_next[DATA_W-1] ? DATA_W'(-running_next) : DATA_W'(running_next);
      neg     <= running_next[DATA_W-1];
      divisor <= count_next;
      div_ovf <= ovf_next;
    end else if (cmd.div_step) begin
      rem <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo <= {quo[DATA_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      value          <= running_next;
      count_overflow <= ovf_next;
    end else if (cmd.load_div) begin
      value          <= neg ? -$signed(quo) : $signed(quo);
      count_overflow <= div_ovf;
    end
  end

endmodule

FILE: rtl/array_min_max_sum_avg_reduce_top.sv
// Top level of the min/max/sum/average reduction block: controller, datapath and checks.
// Throughput: one element transfer per cycle while a run is accumulating and the output register is free.
// A minimum, maximum or sum result is in the output register in the cycle after
// the last element's transfer; an average first runs through the bit-serial divider
// and then waits for a free output register, and no next element is taken meanwhile.
// Reset (rst, synchronous, active high) empties the run state and clears out_valid; the result value is not reset.
module array_min_max_sum_avg_reduce_top
  import amms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic signed [DATA_W-1:0] element,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] value,
  output logic                     count_overflow
);

  // The controller decides when each input transfer is folded in and when the
  // divider runs; the datapath holds all run state and the result register.
  amms_cmd_t    cmd;
  amms_status_t status;

  amms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  amms_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .operation      (operation),
    .element        (element),
    .cmd            (cmd),
    .status         (status),
    .value          (value),
    .count_overflow (count_overflow)
  );

  // While the divider is stepping, no new element transfer may be taken.
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> !in_ready)
    else $error("element accepted during average division");

  // The output register is only loaded when the previous result has left.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_direct || cmd.load_div) |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  // Loading the divider is always followed by a division step.
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> cmd.div_step)
    else $error("divider loaded but not started");

  // At most one of divider start and the two result loads per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.div_start, cmd.load_direct, cmd.load_div}))
    else $error("conflicting result commands");

endmodule
